@@ sv/cle_pkg.sv @@
package cle_pkg;

  typedef logic [2:0] kind_t;
  typedef logic [7:0] byte_t;

  // result kinds
  localparam kind_t KIND_NONE    = 3'd0;
  localparam kind_t KIND_ECHO    = 3'd1;
  localparam kind_t KIND_ERASE   = 3'd2;
  localparam kind_t KIND_READ    = 3'd3;
  localparam kind_t KIND_NOTHING = 3'd4;
  localparam kind_t KIND_EOF     = 3'd5;

  // operation codes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // control characters
  localparam byte_t KEY_NUL    = 8'h00;
  localparam byte_t KEY_CTRL_D = 8'h04;
  localparam byte_t KEY_CTRL_H = 8'h08;
  localparam byte_t KEY_LF     = 8'h0A;
  localparam byte_t KEY_CR     = 8'h0D;
  localparam byte_t KEY_CTRL_P = 8'h10;
  localparam byte_t KEY_CTRL_U = 8'h15;
  localparam byte_t KEY_DEL    = 8'h7F;

  typedef struct packed {
    kind_t kind;
    byte_t byte_value;
    byte_t erase_count;
    logic  line_end;
  } result_t;

endpackage

@@ sv/console_line_editor_core.sv @@
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_op, in_key, in_continuing
// out_      output     out_valid/out_stall out_result_kind, out_byte_value,
//                                         out_erase_count, out_line_end
//
// A key or an empty read passes through ST_IDLE and ST_DONE; a read of a stored byte
// also passes ST_RD_WAIT for the registered line store read.
// Ctrl-U walks back one character at a time through the store read port, alternating
// ST_KILL_RD and ST_KILL_CHK until the commit point or a newline stops the walk.
// Reset (synchronous, rst_n low) zeroes the three pointers; the store needs no clearing.
// The result register holds one result; a new item is taken while it waits,
// and the result stage holds until out_stall drops.
module console_line_editor_core #(
  parameter int BUF_DEPTH = 128
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_op,
  input  cle_pkg::byte_t  in_key,
  input  logic            in_continuing,
  output logic            out_valid,
  input  logic            out_stall,
  output cle_pkg::kind_t  out_result_kind,
  output cle_pkg::byte_t  out_byte_value,
  output cle_pkg::byte_t  out_erase_count,
  output logic            out_line_end
);
  import cle_pkg::*;

  localparam int PW = $clog2(2 * BUF_DEPTH);
  localparam int SW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CW = $clog2(BUF_DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(2 * BUF_DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P = PW'(BUF_DEPTH);
  localparam logic [PW:0]   PTR_MOD = (PW + 1)'(2 * BUF_DEPTH);
  localparam logic [PW:0]   DEPTH_D = (PW + 1)'(BUF_DEPTH);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_RD_WAIT  = 3'd1;
  localparam logic [2:0] ST_KILL_RD  = 3'd2;
  localparam logic [2:0] ST_KILL_CHK = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PTR_MAX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
    return (p == '0) ? PTR_MAX : p - 1'b1;
  endfunction

  function automatic logic [PW:0] ptr_dist(input logic [PW-1:0] a, input logic [PW-1:0] b);
    logic [PW:0] aw;
    logic [PW:0] bw;
    aw = {1'b0, a};
    bw = {1'b0, b};
    return (a >= b) ? aw - bw : aw + PTR_MOD - bw;
  endfunction

  function automatic logic [SW-1:0] slot(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= DEPTH_P) ? p - DEPTH_P : p;
    return s[SW-1:0];
  endfunction

  byte_t mem [BUF_DEPTH];
  byte_t rdata_r;
  logic  mem_we;
  logic [SW-1:0] mem_wa;
  logic [SW-1:0] mem_ra;
  byte_t mem_wd;

  logic [2:0]    state_r, state_nxt;
  logic [PW-1:0] read_r, read_nxt;
  logic [PW-1:0] commit_r, commit_nxt;
  logic [PW-1:0] edit_r, edit_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          cont_r, cont_nxt;
  result_t       pend_r, pend_nxt;
  result_t       out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [12:0]   cnt_wide;
  result_t       kill_res;
  byte_t         store_c;
  logic [PW-1:0] edit_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  always_comb begin
    cnt_wide = 13'(cnt_r);
    kill_res = '0;
    if (cnt_r != '0) begin
      kill_res.kind        = KIND_ERASE;
      kill_res.erase_count = (cnt_wide > 13'd255) ? 8'hFF : cnt_wide[7:0];
    end
    store_c  = (in_key == KEY_CR) ? KEY_LF : in_key;
    edit_inc = ptr_inc(edit_r);
  end

  always_comb begin
    state_nxt     = state_r;
    read_nxt      = read_r;
    commit_nxt    = commit_r;
    edit_nxt      = edit_r;
    cnt_nxt       = cnt_r;
    cont_nxt      = cont_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    mem_wa        = slot(edit_r);
    mem_wd        = store_c;
    mem_ra        = slot(read_r);

    // drop the result once transferred
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          pend_nxt  = '0;
          state_nxt = ST_DONE;
          if (in_op == OP_READ) begin
            cont_nxt = in_continuing;
            if (read_r == commit_r) begin
              pend_nxt.kind = KIND_NOTHING;
            end else begin
              state_nxt = ST_RD_WAIT;
            end
          end else if (in_key == KEY_CTRL_P) begin
            pend_nxt.kind = KIND_NONE;
          end else if (in_key == KEY_CTRL_U) begin
            cnt_nxt   = '0;
            state_nxt = ST_KILL_RD;
          end else if (in_key == KEY_CTRL_H || in_key == KEY_DEL) begin
            if (edit_r != commit_r) begin
              edit_nxt             = ptr_dec(edit_r);
              pend_nxt.kind        = KIND_ERASE;
              pend_nxt.erase_count = 8'd1;
            end
          end else if (in_key != KEY_NUL && ptr_dist(edit_r, read_r) < DEPTH_D) begin
            mem_we   = 1'b1;
            edit_nxt = edit_inc;
            if (store_c == KEY_LF || store_c == KEY_CTRL_D ||
                ptr_dist(edit_inc, read_r) == DEPTH_D) begin
              commit_nxt = edit_inc;
            end
            pend_nxt.kind       = KIND_ECHO;
            pend_nxt.byte_value = store_c;
          end
        end
      end
      ST_RD_WAIT: begin
        pend_nxt  = '0;
        state_nxt = ST_DONE;
        if (rdata_r == KEY_CTRL_D) begin
          // leave a later Ctrl-D in place for the next read
          if (!cont_r) begin
            read_nxt = ptr_inc(read_r);
          end
          pend_nxt.kind = KIND_EOF;
        end else begin
          read_nxt            = ptr_inc(read_r);
          pend_nxt.kind       = KIND_READ;
          pend_nxt.byte_value = rdata_r;
          pend_nxt.line_end   = (rdata_r == KEY_LF);
        end
      end
      ST_KILL_RD: begin
        if (edit_r != commit_r) begin
          mem_ra    = slot(ptr_dec(edit_r));
          state_nxt = ST_KILL_CHK;
        end else begin
          pend_nxt  = kill_res;
          state_nxt = ST_DONE;
        end
      end
      ST_KILL_CHK: begin
        if (rdata_r != KEY_LF) begin
          edit_nxt  = ptr_dec(edit_r);
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_KILL_RD;
        end else begin
          pend_nxt  = kill_res;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      read_r      <= '0;
      commit_r    <= '0;
      edit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      read_r      <= read_nxt;
      commit_r    <= commit_nxt;
      edit_r      <= edit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r  <= cnt_nxt;
    cont_r <= cont_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_r.kind;
  assign out_byte_value  = out_r.byte_value;
  assign out_erase_count = out_r.erase_count;
  assign out_line_end    = out_r.line_end;

endmodule

@@ dv/console_line_editor_core_test.sv @@
module console_line_editor_core_test;
  import cle_pkg::*;

  localparam int DEPTH = 128;
  localparam int PTR_W = $clog2(2 * DEPTH);
  localparam int TARGET_ITEMS = 1650;
  localparam int QUIET_FROM = 1450;

  typedef logic [PTR_W-1:0] ptr_t;

  class line_editor_scoreboard;
    byte_t   line_store [DEPTH];
    ptr_t    rd_ptr;
    ptr_t    cm_ptr;
    ptr_t    ed_ptr;
    result_t expected_q [$];
    result_t last;
    int      mismatches;

    function new();
      foreach (line_store[i]) line_store[i] = KEY_NUL;
      rd_ptr = '0;
      cm_ptr = '0;
      ed_ptr = '0;
      mismatches = 0;
    endfunction

    function int unsigned room();
      return DEPTH - int'(ptr_t'(ed_ptr - rd_ptr));
    endfunction

    function int unsigned committed();
      return int'(ptr_t'(cm_ptr - rd_ptr));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Advance the line state by one accepted transfer and queue its result.
    function void note_item(logic op, byte_t key, logic cont);
      result_t     r;
      ptr_t        prev;
      byte_t       c;
      int unsigned n;
      r = '0;
      if (op == OP_READ) begin
        if (rd_ptr == cm_ptr) begin
          r.kind = KIND_NOTHING;
        end else if (line_store[rd_ptr[PTR_W-2:0]] == KEY_CTRL_D) begin
          r.kind = KIND_EOF;
          // a Ctrl-D inside a request stays for the next request
          if (!cont) rd_ptr = rd_ptr + 1'b1;
        end else begin
          c = line_store[rd_ptr[PTR_W-2:0]];
          r.kind = KIND_READ;
          r.byte_value = c;
          r.line_end = (c == KEY_LF);
          rd_ptr = rd_ptr + 1'b1;
        end
      end else if (key == KEY_CTRL_P) begin
        r.kind = KIND_NONE;
      end else if (key == KEY_CTRL_U) begin
        n = 0;
        prev = ed_ptr - 1'b1;
        while (ed_ptr != cm_ptr && line_store[prev[PTR_W-2:0]] != KEY_LF) begin
          ed_ptr = prev;
          prev = ed_ptr - 1'b1;
          n++;
        end
        if (n != 0) begin
          r.kind = KIND_ERASE;
          r.erase_count = (n > 255) ? 8'd255 : byte_t'(n);
        end
      end else if (key == KEY_CTRL_H || key == KEY_DEL) begin
        if (ed_ptr != cm_ptr) begin
          ed_ptr = ed_ptr - 1'b1;
          r.kind = KIND_ERASE;
          r.erase_count = 8'd1;
        end
      end else if (key != KEY_NUL && int'(ptr_t'(ed_ptr - rd_ptr)) < DEPTH) begin
        c = (key == KEY_CR) ? KEY_LF : key;
        line_store[ed_ptr[PTR_W-2:0]] = c;
        ed_ptr = ed_ptr + 1'b1;
        if (c == KEY_LF || c == KEY_CTRL_D || int'(ptr_t'(ed_ptr - rd_ptr)) == DEPTH)
          cm_ptr = ed_ptr;
        r.kind = KIND_ECHO;
        r.byte_value = c;
      end
      last = r;
      expected_q.push_back(r);
    endfunction

    function void report(string why, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected kind %0d byte %02h erase %0d end %0b, %s",
                 $realtime, why, want.kind, want.byte_value, want.erase_count,
                 want.line_end,
                 $sformatf("got kind %0d byte %02h erase %0d end %0b",
                           got.kind, got.byte_value, got.erase_count, got.line_end));
    endfunction

    function void check_result(kind_t kind, byte_t byte_value, byte_t erase_count,
                               logic line_end);
      result_t got;
      result_t want;
      got.kind = kind;
      got.byte_value = byte_value;
      got.erase_count = erase_count;
      got.line_end = line_end;
      if (expected_q.size() == 0) begin
        report("result with nothing outstanding", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
          got.erase_count !== want.erase_count || got.line_end !== want.line_end)
        report("result mismatch", want, got);
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic           in_op = OP_KEY;
  byte_t          in_key = KEY_NUL;
  logic           in_continuing = 1'b0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  kind_t          out_result_kind;
  byte_t          out_byte_value;
  byte_t          out_erase_count;
  logic           out_line_end;

  line_editor_scoreboard sb;
  bit quiet = 1'b0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int stall_left = 0;
  int effective = 0;
  int fills_done = 0;

  console_line_editor_core #(.BUF_DEPTH(DEPTH)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_key         (in_key),
    .in_continuing  (in_continuing),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_kind(out_result_kind),
    .out_byte_value (out_byte_value),
    .out_erase_count(out_erase_count),
    .out_line_end   (out_line_end)
  );

  always #1 clk = ~clk;

  // Check accepted results and drive receiver stall bursts.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_result_kind, out_byte_value, out_erase_count, out_line_end);
    if (quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_stall <= 1'b0;
    end else if (!recv_calm && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 19);
    end
    if ($urandom_range(0, 199) == 0) recv_calm <= !recv_calm;
  end

  function automatic byte_t printable();
    return byte_t'($urandom_range(8'h20, 8'h7E));
  endfunction

  // Returns in the step of acceptance; valid stays high for a following transfer.
  task automatic send_item(logic op, byte_t key, logic cont);
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
    if (!quiet && !send_calm && $urandom_range(0, 7) == 0) begin
      if (in_valid) in_valid <= 1'b0;
      in_key <= byte_t'($urandom);
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= key;
    in_continuing <= cont;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_item(op, key, cont);
    if (sb.last.kind != KIND_NONE) effective++;
  endtask

  task automatic send_key(byte_t key);
    send_item(OP_KEY, key, $urandom_range(0, 1) != 0);
  endtask

  task automatic send_read(logic cont);
    send_item(OP_READ, byte_t'($urandom), cont);
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One read request: continue until a line end, end of file, nothing left or max_bytes reads.
  task automatic read_request(int unsigned max_bytes);
    logic        cont;
    int unsigned n;
    cont = 1'b0;
    n = 0;
    do begin
      send_read(cont);
      cont = 1'b1;
      n++;
    end while (sb.last.kind == KIND_READ && !sb.last.line_end && n < max_bytes);
  endtask

  task automatic type_line(int unsigned len);
    int unsigned pick;
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) send_key(($urandom_range(0, 1) != 0) ? KEY_CTRL_H : KEY_DEL);
      else if (pick < 10) send_key(KEY_CTRL_U);
      else if (pick < 20) send_key(byte_t'($urandom));
      else send_key(printable());
    end
    pick = $urandom_range(0, 9);
    if (pick < 4) send_key(KEY_CR);
    else if (pick < 7) send_key(KEY_LF);
    else if (pick < 9) send_key(KEY_CTRL_D);
  endtask

  // Fill to the brim, poke the full buffer, then read it all back.
  task automatic fill_and_empty();
    while (sb.room() != 0) send_key(printable());
    repeat (3) send_key(byte_t'($urandom));
    send_key(KEY_CTRL_H);
    send_key(KEY_CTRL_U);
    while (sb.committed() != 0) read_request(DEPTH);
    send_read(1'b0);
  endtask

  task automatic kill_long_line();
    int unsigned len;
    if (sb.room() > 40) begin
      len = $urandom_range(30, sb.room() - 1);
      repeat (len) send_key(printable());
      send_key(KEY_CTRL_U);
    end
  endtask

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned pick;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty buffer: nothing to read or erase, ignored keys
    send_read(1'b0);
    send_key(KEY_CTRL_H);
    send_key(KEY_DEL);
    send_key(KEY_CTRL_U);
    send_key(KEY_NUL);
    send_key(KEY_CTRL_P);
    // single erases and a kill over a mixed line
    send_key(8'h61);
    send_key(8'hFF);
    send_key(8'h80);
    send_key(KEY_DEL);
    send_key(KEY_CTRL_H);
    send_key(8'h62);
    send_key(KEY_CTRL_P);
    send_key(KEY_CTRL_U);
    // CR commits as LF; committed text is not erasable
    send_key(8'h78);
    send_key(KEY_CR);
    send_key(KEY_CTRL_H);
    send_read(1'b0);
    send_read(1'b1);
    send_read(1'b0);
    // end of file: held inside a request, consumed at the start of one
    send_key(KEY_CTRL_D);
    send_read(1'b1);
    send_read(1'b0);
    send_read(1'b0);
    send_key(8'h79);
    send_key(KEY_LF);
    read_request(4);
    drain();

    while (effective < TARGET_ITEMS) begin
      if (effective >= QUIET_FROM) quiet = 1'b1;
      if (fills_done < 2 && effective >= 500 + fills_done * 550) begin
        fill_and_empty();
        fills_done++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        type_line(($urandom_range(0, 3) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12));
        if ($urandom_range(0, 4) != 0) read_request(40);
      end else if (pick < 75) begin
        read_request($urandom_range(1, 40));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6))
          send_item($urandom_range(0, 1) != 0, byte_t'($urandom), $urandom_range(0, 1) != 0);
      end else if (pick < 96) begin
        kill_long_line();
      end else begin
        drain();
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
